// ===== rtl/esc_pkg.sv =====
// Shared types, constants and the field-code decoder of the exec field code stripper.
package esc_pkg;

	localparam int unsigned BUFFER_BYTES_DEFAULT = 1024;
	localparam int unsigned QUEUE_DEPTH_DEFAULT  = 2;

	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// One input transaction: a byte of the command line and its framing.
	typedef struct packed {
		logic [7:0] in_char;
		logic       has_char;
		logic       is_last;
	} cmd_item_t;

	// One output transaction: a byte of the cleaned line and its framing.
	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       end_of_text;
	} res_item_t;

	// Work left by one input item: up to three bytes, then maybe the end mark.
	typedef struct packed {
		logic [2:0][7:0] chars;
		logic [1:0]      n_chars;
		logic            end_of_text;
	} plan_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic is_known_code(input logic [7:0] c);
		logic known;
		known = 1'b0;
		case (c) inside
			"f", "F", "u", "U", "d", "D", "n", "N",
			"v", "m", "i", "c", "k": known = 1'b1;
			default: known = 1'b0;
		endcase
		return known;
	endfunction

endpackage

// ===== rtl/exec_field_code_stripper.sv =====
// Top level of the exec field code stripper: front end, plan queue and back end.
// Cleans a command line that arrives one byte per transaction. A '%' is held for
// its code byte: "%%" gives '%', the field codes f F u U d D n N v m i c k vanish,
// any other code passes as two bytes, and a '%' at the very end passes as is.
// Bytes past BUFFER_BYTES - 1 survivors are discarded, and runs of spaces collapse
// to one space written just before the next other byte and dropped at the end.
// A transaction with is_last closes the line: its last output transaction carries
// end_of_text, or a lone end-only transaction does when it gave no byte. Input
// transactions are taken back to back while the plan queue has room; the output
// side issues one byte per cycle while a plan is queued and res_ready is high (up
// to three per input byte, one for an end-only result); the output register plus
// the queue let the sides stall apart. There are no configuration registers.
module exec_field_code_stripper import esc_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
	parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_item_t cmd,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	logic        push;
	logic        pop;
	plan_t       wr_plan;
	plan_t       head;
	queue_stat_t qstat;

	// Decode percent codes, apply the capacity limit and collapse spaces.
	esc_front #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.qstat    (qstat),
		.push     (push),
		.plan     (wr_plan)
	);

	// Hold finished plans until the back end drains them.
	esc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_plan(wr_plan),
		.pop    (pop),
		.rd_plan(head),
		.qstat  (qstat)
	);

	// Issue the bytes of each plan, one output transaction per cycle while res_ready is high.
	esc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(!qstat.empty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// An end-only transaction is always a zero byte that closes the line.
	a_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.char_valid |-> res.end_of_text && res.out_char == 8'h00)
		else $error("end-only transaction malformed");

	// A held space is dropped at the end, so a line never ends in a space.
	a_no_trailing_space: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.end_of_text && res.char_valid |-> res.out_char != CHAR_SPACE)
		else $error("line ends in a space");

	// The queue cannot be full and empty at once.
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.full && qstat.empty))
		else $error("queue level inconsistent");

	// A pop only happens while a plan is queued.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

// ===== rtl/esc_front.sv =====
// Front end: percent decoding, capacity limit and space collapsing of each input byte.
module esc_front import esc_pkg::*; #(
	parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_item_t   cmd,
	input  queue_stat_t qstat,
	output logic        push,
	output plan_t       plan
);

	localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
	localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(BUFFER_BYTES - 1);

	logic             percent_q;
	logic             space_q;
	logic [CNT_W-1:0] count_q;

	logic             pct_next;
	logic             sp_next;
	logic [CNT_W-1:0] count_next;
	logic [1:0][7:0]  cand;
	logic [1:0]       n_cand;
	logic [1:0]       take;
	logic             room0;
	logic             room1;
	logic             accept;

	assign room0 = {1'b0, count_q} < LIMIT;
	assign room1 = ({1'b0, count_q} + (CNT_W + 1)'(1)) < LIMIT;

	always_comb begin
		n_cand   = 2'd0;
		cand[0]  = cmd.in_char;
		cand[1]  = cmd.in_char;
		pct_next = percent_q;
		if (cmd.has_char) begin
			if (percent_q) begin
				pct_next = 1'b0;
				if (cmd.in_char == CHAR_PERCENT) begin
					n_cand  = 2'd1;
					cand[0] = CHAR_PERCENT;
				end else if (!is_known_code(cmd.in_char)) begin
					n_cand  = 2'd2;
					cand[0] = CHAR_PERCENT;
				end
			end else if (cmd.in_char == CHAR_PERCENT) begin
				pct_next = room0;
			end else begin
				n_cand = 2'd1;
			end
		end
		// flush a percent still held at the end of the line
		if (cmd.is_last && pct_next) begin
			n_cand   = 2'd1;
			cand[0]  = CHAR_PERCENT;
			pct_next = 1'b0;
		end
		take[0] = (n_cand != 2'd0) && room0;
		take[1] = (n_cand == 2'd2) && room1;
	end

	always_comb begin
		plan.chars       = '0;
		plan.n_chars     = 2'd0;
		plan.end_of_text = cmd.is_last;
		sp_next          = space_q;
		for (int i = 0; i < 2; i++) begin
			if (take[i]) begin
				if (cand[i] == CHAR_SPACE) begin
					sp_next = 1'b1;
				end else begin
					if (sp_next) begin
						plan.chars[plan.n_chars] = CHAR_SPACE;
						plan.n_chars             = plan.n_chars + 2'd1;
					end
					plan.chars[plan.n_chars] = cand[i];
					plan.n_chars             = plan.n_chars + 2'd1;
					sp_next                  = 1'b0;
				end
			end
		end
		count_next = count_q + CNT_W'(take[0]) + CNT_W'(take[1]);
	end

	assign cmd_ready = !qstat.full;
	assign accept    = cmd_valid && cmd_ready;
	assign push      = accept && ((plan.n_chars != 2'd0) || cmd.is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			percent_q <= 1'b0;
			space_q   <= 1'b0;
			count_q   <= '0;
		end else if (accept) begin
			if (cmd.is_last) begin
				percent_q <= 1'b0;
				space_q   <= 1'b0;
				count_q   <= '0;
			end else begin
				percent_q <= pct_next;
				space_q   <= sp_next;
				count_q   <= count_next;
			end
		end
	end

endmodule

// ===== rtl/esc_queue.sv =====
// Small show-ahead queue of plans between the front and back ends.
module esc_queue import esc_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  plan_t       wr_plan,
	input  logic        pop,
	output plan_t       rd_plan,
	output queue_stat_t qstat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned LVL_W = $clog2(DEPTH + 1);

	plan_t            slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign qstat.full  = level_q == LVL_W'(DEPTH);
	assign qstat.empty = level_q == '0;
	assign rd_plan     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + LVL_W'(1);
				2'b01:   level_q <= level_q - LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ===== rtl/esc_back.sv =====
// Back end: walks each queued plan and issues its bytes through the output register.
module esc_back import esc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  plan_t     head,
	input  logic      head_valid,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	logic [1:0] idx_q;
	logic       load;
	logic       last_of_plan;
	res_item_t  next_res;

	assign load         = !res_valid || res_ready;
	assign last_of_plan = (head.n_chars == 2'd0) || (idx_q == head.n_chars - 2'd1);
	assign pop          = load && head_valid && last_of_plan;

	always_comb begin
		if (head.n_chars == 2'd0) begin
			next_res = '{out_char: 8'h00, char_valid: 1'b0, end_of_text: 1'b1};
		end else begin
			next_res.out_char    = head.chars[idx_q];
			next_res.char_valid  = 1'b1;
			next_res.end_of_text = head.end_of_text && last_of_plan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			idx_q     <= 2'd0;
		end else if (load) begin
			res_valid <= head_valid;
			if (head_valid) begin
				idx_q <= last_of_plan ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			res <= next_res;
		end
	end

endmodule
